// File: src/bmmd_pkg.sv
`default_nettype none
package bmmd_pkg;

	localparam int PIX_W   = 8;
	localparam int ACC_W   = 20;
	localparam int SKIP_W  = 5;
	localparam int MODE_W  = 2;
	localparam int DW_W    = 11;
	localparam int DH_W    = 13;
	localparam int SCALE_W = 15;
	localparam int HALF_W  = 9;
	localparam int MEAN_SHIFT = 14;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_MODE       = 2'd0;
	localparam logic [1:0] REG_SKIP       = 2'd1;
	localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
	localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

	// Reduction modes; the two unused codes behave as the mean.
	localparam logic [MODE_W-1:0] MODE_MAX = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MIN = 2'd1;

	localparam logic [MODE_W-1:0] RST_MODE       = MODE_MAX;
	localparam logic [SKIP_W-1:0] RST_SKIP       = 5'd2;
	localparam logic [DW_W-1:0]   RST_DST_WIDTH  = 11'd512;
	localparam logic [DH_W-1:0]   RST_DST_HEIGHT = 13'd512;

	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = 2;
	localparam int OUTQ_CNT_W = 3;

	// Per-pixel decision taken when the pixel is accepted.
	typedef struct packed {
		logic in_rng;
		logic first;
		logic emit;
		logic row_done;
		logic frame_done;
	} pos_info_t;

	typedef struct packed {
		logic             frame_done;
		logic             row_done;
		logic [PIX_W-1:0] value;
	} out_word_t;

	// floor(16384 / (s*s)) for block sides 1..31.
	function automatic logic [SCALE_W-1:0] scale_lut(input logic [SKIP_W-1:0] s);
		logic [SCALE_W-1:0] r;
		case (s)
			5'd1:    r = 15'd16384;
			5'd2:    r = 15'd4096;
			5'd3:    r = 15'd1820;
			5'd4:    r = 15'd1024;
			5'd5:    r = 15'd655;
			5'd6:    r = 15'd455;
			5'd7:    r = 15'd334;
			5'd8:    r = 15'd256;
			5'd9:    r = 15'd202;
			5'd10:   r = 15'd163;
			5'd11:   r = 15'd135;
			5'd12:   r = 15'd113;
			5'd13:   r = 15'd96;
			5'd14:   r = 15'd83;
			5'd15:   r = 15'd72;
			5'd16:   r = 15'd64;
			5'd17:   r = 15'd56;
			5'd18:   r = 15'd50;
			5'd19:   r = 15'd45;
			5'd20:   r = 15'd40;
			5'd21:   r = 15'd37;
			5'd22:   r = 15'd33;
			5'd23:   r = 15'd30;
			5'd24:   r = 15'd28;
			5'd25:   r = 15'd26;
			5'd26:   r = 15'd24;
			5'd27:   r = 15'd22;
			5'd28:   r = 15'd20;
			5'd29:   r = 15'd19;
			5'd30:   r = 15'd18;
			5'd31:   r = 15'd17;
			default: r = 15'd16384;
		endcase
		return r;
	endfunction

	// floor(s*s / 2), the rounding offset of the mean.
	function automatic logic [HALF_W-1:0] half_area_lut(input logic [SKIP_W-1:0] s);
		logic [HALF_W-1:0] r;
		case (s)
			5'd2:    r = 9'd2;
			5'd3:    r = 9'd4;
			5'd4:    r = 9'd8;
			5'd5:    r = 9'd12;
			5'd6:    r = 9'd18;
			5'd7:    r = 9'd24;
			5'd8:    r = 9'd32;
			5'd9:    r = 9'd40;
			5'd10:   r = 9'd50;
			5'd11:   r = 9'd60;
			5'd12:   r = 9'd72;
			5'd13:   r = 9'd84;
			5'd14:   r = 9'd98;
			5'd15:   r = 9'd112;
			5'd16:   r = 9'd128;
			5'd17:   r = 9'd144;
			5'd18:   r = 9'd162;
			5'd19:   r = 9'd180;
			5'd20:   r = 9'd200;
			5'd21:   r = 9'd220;
			5'd22:   r = 9'd242;
			5'd23:   r = 9'd264;
			5'd24:   r = 9'd288;
			5'd25:   r = 9'd312;
			5'd26:   r = 9'd338;
			5'd27:   r = 9'd364;
			5'd28:   r = 9'd392;
			5'd29:   r = 9'd420;
			5'd30:   r = 9'd450;
			5'd31:   r = 9'd480;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: src/bmmd_ram.sv
`default_nettype none
module bmmd_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: src/bmmd_pos.sv
`default_nettype none
module bmmd_pos
	import bmmd_pkg::*;
#(
	parameter int MAX_OUT_WIDTH = 1024,
	parameter int MAX_BLOCK = 16,
	localparam int BLK_EFF = (MAX_BLOCK < 31) ? MAX_BLOCK : 31,
	localparam int CB_W = (BLK_EFF > 1) ? $clog2(BLK_EFF) : 1,
	localparam int OC_W = $clog2(MAX_OUT_WIDTH + 1),
	localparam int WC_W = (OC_W > DW_W) ? OC_W : DW_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              sof,
	input  wire logic              eol,
	input  wire logic [SKIP_W-1:0] s_eff,
	input  wire logic [WC_W-1:0]   w_eff,
	input  wire logic [DH_W-1:0]   h_eff,
	output pos_info_t              info,
	output logic      [OC_W-1:0]   out_col
);

	logic [CB_W-1:0] col_q, row_q;
	logic [OC_W-1:0] ocol_q;
	logic [DH_W-1:0] orow_q;

	logic [CB_W-1:0] col_c, row_c;
	logic [OC_W-1:0] ocol_c;
	logic [DH_W-1:0] orow_c;
	logic            last_col, last_row, row_ok;

	// A start of frame clears the counters before its own pixel is used.
	always_comb begin
		col_c    = sof ? '0 : col_q;
		row_c    = sof ? '0 : row_q;
		ocol_c   = sof ? '0 : ocol_q;
		orow_c   = sof ? '0 : orow_q;
		last_col = ({1'b0, 5'(col_c)} + 6'd1) >= {1'b0, s_eff};
		last_row = ({1'b0, 5'(row_c)} + 6'd1) >= {1'b0, s_eff};
		row_ok   = orow_c < h_eff;
		info.in_rng     = (WC_W'(ocol_c) < w_eff) && row_ok;
		info.first      = (col_c == '0) && (row_c == '0);
		info.emit       = info.in_rng && last_col && last_row;
		info.row_done   = (WC_W'(ocol_c) + WC_W'(1)) == w_eff;
		info.frame_done = info.row_done && ((orow_c + DH_W'(1)) == h_eff);
		out_col = ocol_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (accept) begin
			if (eol) begin
				col_q  <= '0;
				ocol_q <= '0;
			end else if (info.in_rng) begin
				if (last_col) begin
					col_q  <= '0;
					ocol_q <= ocol_c + OC_W'(1);
				end else begin
					col_q  <= col_c + CB_W'(1);
					ocol_q <= ocol_c;
				end
			end else begin
				col_q  <= col_c;
				ocol_q <= ocol_c;
			end
			if (eol && row_ok) begin
				if (last_row) begin
					row_q  <= '0;
					orow_q <= orow_c + DH_W'(1);
				end else begin
					row_q  <= row_c + CB_W'(1);
					orow_q <= orow_c;
				end
			end else begin
				row_q  <= row_c;
				orow_q <= orow_c;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/bmmd_outq.sv
`default_nettype none
module bmmd_outq
	import bmmd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire out_word_t             wdata,
	input  wire logic                  pop,
	output logic                       valid,
	output out_word_t                  rdata,
	output logic      [OUTQ_CNT_W-1:0] count
);

	out_word_t             entry_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUTQ_CNT_W-1:0] count_q;
	logic                  do_pop;

	assign valid  = count_q != '0;
	assign rdata  = entry_q[rd_ptr_q];
	assign count  = count_q;
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// Pushes are admitted upstream only when a slot is reserved.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + OUTQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + OUTQ_PTR_W'(1);
			end
			count_q <= count_q + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(do_pop);
		end
	end

endmodule
`default_nettype wire

// File: src/block_min_max_mean_downscaler_top.sv
`default_nettype none
// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid / s_tready  source pixel word, one per source pixel
// m_*       out        m_tvalid / m_tready  reduced pixel word, one per finished block
// apb       in         psel, penable        mode, skip, dst_width, dst_height
//
// One pixel word is taken per clock while s_tready is high. The rate is set by the
// read-modify-write of the column accumulator RAM, whose read-during-write is covered
// by forwarding. A result word passes stage 1 and stage 2 before the output queue.
// s_tready drops only while the four-word output queue, counting results still in
// the pipeline, is full; a stalled consumer thus stalls the source after four words.
// Reset clears the counters, the pipeline and the queue; the accumulator RAM is not
// cleared, since the first pixel of every block overwrites its entry.
module block_min_max_mean_downscaler_top
	import bmmd_pkg::*;
#(
	parameter int MAX_OUT_WIDTH = 1024,
	parameter int MAX_BLOCK = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// Source pixels.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] pixel
	input  wire logic [0:0]  s_tuser,   // [0] start_of_frame
	input  wire logic        s_tlast,   // end_of_line
	// Reduced pixels.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [7:0]  m_tdata,   // [7:0] value
	output logic      [0:0]  m_tuser,   // [0] frame_done
	output logic             m_tlast    // row_done
);

	localparam int AW   = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
	localparam int OC_W = $clog2(MAX_OUT_WIDTH + 1);
	localparam int WC_W = (OC_W > DW_W) ? OC_W : DW_W;
	localparam int PROD_W = ACC_W + 1 + SCALE_W;

	// Configuration registers.
	logic [MODE_W-1:0] mode_q;
	logic [SKIP_W-1:0] skip_q;
	logic [DW_W-1:0]   dst_width_q;
	logic [DH_W-1:0]   dst_height_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= RST_MODE;
			skip_q       <= RST_SKIP;
			dst_width_q  <= RST_DST_WIDTH;
			dst_height_q <= RST_DST_HEIGHT;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_MODE:       mode_q       <= pwdata[MODE_W-1:0];
				REG_SKIP:       skip_q       <= pwdata[SKIP_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= pwdata[DW_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= pwdata[DH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MODE:       prdata = {{(32-MODE_W){1'b0}}, mode_q};
			REG_SKIP:       prdata = {{(32-SKIP_W){1'b0}}, skip_q};
			REG_DST_WIDTH:  prdata = {{(32-DW_W){1'b0}}, dst_width_q};
			REG_DST_HEIGHT: prdata = {{(32-DH_W){1'b0}}, dst_height_q};
			default:        prdata = '0;
		endcase
	end

	// Effective block side, row width and frame height. A zero means one, and the
	// block side and row width are clamped to their build limits.
	logic [SKIP_W-1:0] s_eff;
	logic [WC_W-1:0]   w_eff;
	logic [DH_W-1:0]   h_eff;

	always_comb begin
		if (skip_q == '0) begin
			s_eff = SKIP_W'(1);
		end else if (int'(skip_q) > MAX_BLOCK) begin
			s_eff = SKIP_W'(MAX_BLOCK);
		end else begin
			s_eff = skip_q;
		end
		if (dst_width_q == '0) begin
			w_eff = WC_W'(1);
		end else if (WC_W'(dst_width_q) > WC_W'(MAX_OUT_WIDTH)) begin
			w_eff = WC_W'(MAX_OUT_WIDTH);
		end else begin
			w_eff = WC_W'(dst_width_q);
		end
		h_eff = (dst_height_q == '0) ? DH_W'(1) : dst_height_q;
	end

	// Stage 0: accept a pixel, place it in its block and issue the RAM read.
	logic      accept;
	pos_info_t info;
	logic [OC_W-1:0] out_col;
	logic [AW-1:0]   rd_addr;

	assign accept  = s_tvalid && s_tready;
	assign rd_addr = out_col[AW-1:0];

	bmmd_pos #(
		.MAX_OUT_WIDTH(MAX_OUT_WIDTH),
		.MAX_BLOCK(MAX_BLOCK)
	) u_pos (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.sof(s_tuser[0]),
		.eol(s_tlast),
		.s_eff(s_eff),
		.w_eff(w_eff),
		.h_eff(h_eff),
		.info(info),
		.out_col(out_col)
	);

	// Stage 1: merge the pixel into the column accumulator and write it back.
	logic             valid_s1, first_s1, emit_s1, rd_s1, fd_s1, fwd_s1;
	logic [AW-1:0]    addr_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [ACC_W-1:0] acc_fwd_q, ram_rdata, acc_old_s1, acc_new_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept && info.in_rng;
			// The pixel just ahead writes the same column at this very edge, so
			// the RAM read would miss it.
			fwd_s1   <= accept && info.in_rng && valid_s1 && (rd_addr == addr_s1);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1  <= rd_addr;
		pix_s1   <= s_tdata;
		first_s1 <= info.first;
		emit_s1  <= info.emit;
		rd_s1    <= info.row_done;
		fd_s1    <= info.frame_done;
		if (valid_s1) begin
			acc_fwd_q <= acc_new_s1;
		end
	end

	bmmd_ram #(
		.WIDTH(ACC_W),
		.DEPTH(MAX_OUT_WIDTH)
	) u_acc_ram (
		.clk(clk),
		.we(valid_s1),
		.waddr(addr_s1),
		.wdata(acc_new_s1),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		acc_old_s1 = fwd_s1 ? acc_fwd_q : ram_rdata;
		if (first_s1) begin
			acc_new_s1 = ACC_W'(pix_s1);
		end else begin
			case (mode_q)
				MODE_MAX: acc_new_s1 = (ACC_W'(pix_s1) > acc_old_s1) ? ACC_W'(pix_s1)
				                                                      : acc_old_s1;
				MODE_MIN: acc_new_s1 = (ACC_W'(pix_s1) < acc_old_s1) ? ACC_W'(pix_s1)
				                                                      : acc_old_s1;
				default:  acc_new_s1 = acc_old_s1 + ACC_W'(pix_s1);
			endcase
		end
	end

	// Stage 2: finish the block value and push it into the output queue.
	logic             valid_s2, rd_s2, fd_s2;
	logic [ACC_W-1:0] acc_s2;
	logic [ACC_W:0]   sum_rnd_s2;
	logic [PROD_W-1:0] prod_s2;
	out_word_t        word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		acc_s2 <= acc_new_s1;
		rd_s2  <= rd_s1;
		fd_s2  <= fd_s1;
	end

	// The mean is a multiply by the reciprocal of the block area.
	always_comb begin
		sum_rnd_s2 = {1'b0, acc_s2} + (ACC_W + 1)'(half_area_lut(s_eff));
		prod_s2    = PROD_W'(sum_rnd_s2) * PROD_W'(scale_lut(s_eff));
		word_s2.row_done   = rd_s2;
		word_s2.frame_done = fd_s2;
		if (mode_q == MODE_MAX || mode_q == MODE_MIN) begin
			word_s2.value = acc_s2[PIX_W-1:0];
		end else begin
			word_s2.value = prod_s2[MEAN_SHIFT +: PIX_W];
		end
	end

	// Output queue. Input is taken only while every result that may still come
	// out of the pipeline has a slot waiting for it.
	logic                  q_valid;
	out_word_t             q_word;
	logic [OUTQ_CNT_W-1:0] q_count, reserved;

	bmmd_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(valid_s2),
		.wdata(word_s2),
		.pop(m_tready),
		.valid(q_valid),
		.rdata(q_word),
		.count(q_count)
	);

	assign reserved = q_count + OUTQ_CNT_W'(valid_s1 && emit_s1) + OUTQ_CNT_W'(valid_s2);
	assign s_tready = reserved < OUTQ_CNT_W'(OUTQ_DEPTH);

	assign m_tvalid   = q_valid;
	assign m_tdata    = q_word.value;
	assign m_tlast    = q_word.row_done;
	assign m_tuser[0] = q_word.frame_done;

endmodule
`default_nettype wire

// File: src/bmmd_checker.sv
`default_nettype none
module bmmd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [0:0] m_tuser,
	input wire logic       m_tlast
);

	// A stalled result word keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
		&& $stable(m_tuser))
		else $error("result word changed while stalled");

	// The last word of a frame is also the last of its row.
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("frame_done without row_done");

	// With the output queue empty the source is never held off.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("source stalled with empty output queue");

	// A result appearing on an empty queue comes from a pixel taken through stage 1 and stage 2.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
		else $error("result word without a matching source word");

endmodule

bind block_min_max_mean_downscaler_top bmmd_checker u_bmmd_checker (.*);
`default_nettype wire
